### hdl/chs_pkg.sv
// Shared types and constants for the chained hash set.
// Used by chs_ctrl, chs_dp and chained_hash_set; depends on nothing.
`default_nettype none

package chs_pkg;

    localparam int BUCKETS_DEF    = 13;
    localparam int POOL_NODES_DEF = 64;
    localparam int KEY_BYTES_DEF  = 9;

    localparam int KEY_W     = 72;
    localparam int SUM_W     = 12;
    localparam int RCP_SH    = 24;
    localparam int MOD_STEPS = 2;
    localparam int BIDX_W    = 4;
    localparam int MSTEP_W   = 1;
    localparam int STATUS_W  = 3;
    localparam int BUCKET_W  = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_POOL_FULL = 3'd4
    } t_status;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_MOD,
        S_HEAD_RD,
        S_HEAD_TAKE,
        S_WALK,
        S_CMP,
        S_APPEND,
        S_TERM,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    load;
        logic    sum_step;
        logic    mod_step;
        logic    head_rd;
        logic    head_take;
        logic    node_rd;
        logic    node_adv;
        logic    append_link;
        logic    append_term;
        logic    set_status;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic sum_last;
        logic mod_last;
        logic walk_ok;
        logic key_match;
        logic pool_full;
        logic is_search;
    } t_dp_stat;

endpackage

`default_nettype wire

### hdl/chs_ctrl.sv
// Controller state machine of the chained hash set.
// Issues datapath commands and reads datapath status; uses chs_pkg.
`default_nettype none

module chs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   o_valid,
    output chs_pkg::t_dp_cmd       o_cmd,
    input  wire chs_pkg::t_dp_stat i_stat
);

    chs_pkg::t_state r_state;
    chs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chs_pkg::S_IDLE: begin
                if (start) begin
                    n_state = chs_pkg::S_SUM;
                end
            end
            chs_pkg::S_SUM: begin
                if (i_stat.sum_last) begin
                    n_state = chs_pkg::S_MOD;
                end
            end
            chs_pkg::S_MOD: begin
                if (i_stat.mod_last) begin
                    n_state = chs_pkg::S_HEAD_RD;
                end
            end
            chs_pkg::S_HEAD_RD:   n_state = chs_pkg::S_HEAD_TAKE;
            chs_pkg::S_HEAD_TAKE: n_state = chs_pkg::S_WALK;
            chs_pkg::S_WALK: begin
                if (i_stat.walk_ok) begin
                    n_state = chs_pkg::S_CMP;
                end else if (i_stat.is_search || i_stat.pool_full) begin
                    n_state = chs_pkg::S_DONE;
                end else begin
                    n_state = chs_pkg::S_APPEND;
                end
            end
            chs_pkg::S_CMP: begin
                if (i_stat.key_match) begin
                    n_state = chs_pkg::S_DONE;
                end else begin
                    n_state = chs_pkg::S_WALK;
                end
            end
            chs_pkg::S_APPEND: n_state = chs_pkg::S_TERM;
            chs_pkg::S_TERM:   n_state = chs_pkg::S_DONE;
            chs_pkg::S_DONE:   n_state = chs_pkg::S_IDLE;
            default:           n_state = chs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = chs_pkg::ST_INSERTED;
        busy         = (r_state != chs_pkg::S_IDLE);
        o_valid      = (r_state == chs_pkg::S_DONE);
        unique case (r_state)
            chs_pkg::S_IDLE:      o_cmd.load      = start;
            chs_pkg::S_SUM:       o_cmd.sum_step  = 1'b1;
            chs_pkg::S_MOD:       o_cmd.mod_step  = 1'b1;
            chs_pkg::S_HEAD_RD:   o_cmd.head_rd   = 1'b1;
            chs_pkg::S_HEAD_TAKE: o_cmd.head_take = 1'b1;
            chs_pkg::S_WALK: begin
                if (i_stat.walk_ok) begin
                    o_cmd.node_rd = 1'b1;
                end else if (i_stat.is_search) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = chs_pkg::ST_NOT_FOUND;
                end else if (i_stat.pool_full) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = chs_pkg::ST_POOL_FULL;
                end
            end
            chs_pkg::S_CMP: begin
                if (i_stat.key_match) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = i_stat.is_search ? chs_pkg::ST_FOUND
                                                        : chs_pkg::ST_DUPLICATE;
                end else begin
                    o_cmd.node_adv = 1'b1;
                end
            end
            chs_pkg::S_APPEND: o_cmd.append_link = 1'b1;
            chs_pkg::S_TERM: begin
                o_cmd.append_term = 1'b1;
                o_cmd.set_status  = 1'b1;
                o_cmd.status      = chs_pkg::ST_INSERTED;
            end
            chs_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/chs_dp.sv
// Datapath of the chained hash set: key capture, bucket hash, bucket heads,
// node pool memories and chain walk registers. Uses chs_pkg.
`default_nettype none

module chs_dp #(
    parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF,
    parameter int KEY_BYTES  = chs_pkg::KEY_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd,
    input  wire logic [63:0]                   i_key_head,
    input  wire logic [7:0]                    i_key_tail,
    input  wire chs_pkg::t_dp_cmd              i_ctl,
    output chs_pkg::t_dp_stat                  o_stat,
    output logic [chs_pkg::STATUS_W-1:0]       o_status,
    output logic [chs_pkg::BUCKET_W-1:0]       o_bucket
);

    localparam int IDX_W  = $clog2(POOL_NODES + 1);
    localparam int PIDX_W = $clog2(POOL_NODES);
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int PROD_W = chs_pkg::SUM_W + chs_pkg::RCP_SH;
    localparam logic [chs_pkg::RCP_SH-1:0] RCP =
        chs_pkg::RCP_SH'(((1 << chs_pkg::RCP_SH) + BUCKETS - 1) / BUCKETS);
    localparam logic [IDX_W-1:0] NULL_NODE = IDX_W'(POOL_NODES);

    logic [chs_pkg::KEY_W-1:0]   r_key;
    logic                        r_search;
    logic [chs_pkg::SUM_W-1:0]   r_acc;
    logic [chs_pkg::SUM_W-1:0]   r_quot;
    logic [chs_pkg::BIDX_W-1:0]  r_bidx;
    logic [chs_pkg::MSTEP_W-1:0] r_mstep;
    logic [IDX_W-1:0]            r_node;
    logic [IDX_W-1:0]            r_last;
    logic [IDX_W-1:0]            r_steps;
    logic [IDX_W-1:0]            r_used;
    chs_pkg::t_status            r_status;

    logic [IDX_W-1:0]            r_bh_mem [BUCKETS];
    logic [BUCKETS-1:0]          r_bh_valid;
    logic [IDX_W-1:0]            r_bh_rd;
    logic                        r_bh_rdv;

    logic [chs_pkg::KEY_W-1:0]   r_key_mem [POOL_NODES];
    logic [IDX_W-1:0]            r_next_mem [POOL_NODES];
    logic [chs_pkg::KEY_W-1:0]   r_rd_key;
    logic [IDX_W-1:0]            r_rd_next;

    logic [chs_pkg::KEY_W-1:0]   w_norm;
    logic [chs_pkg::KEY_W-1:0]   w_raw;
    logic                        w_alive;
    logic [7:0]                  w_byte;
    logic [PROD_W-1:0]           w_prod;
    logic [chs_pkg::SUM_W-1:0]   w_quot;
    logic [chs_pkg::SUM_W-1:0]   w_qmul;
    logic [BKT_W-1:0]            w_bkt;

    assign w_raw = {i_key_tail, i_key_head};

    always_comb begin
        w_norm  = '0;
        w_alive = 1'b1;
        for (int i = 0; i < 9; i++) begin
            w_alive = w_alive && (w_raw[8*i +: 8] != 8'd0) && (i < KEY_BYTES);
            if (w_alive) begin
                w_norm[8*i +: 8] = w_raw[8*i +: 8];
            end
        end
    end

    // The bucket is the sum minus the bucket count times a quotient taken
    // from a reciprocal product; the sum is small enough that it is exact.
    assign w_byte = r_key[8*r_bidx +: 8];
    assign w_prod = PROD_W'(r_acc) * PROD_W'(RCP);
    assign w_quot = w_prod[chs_pkg::RCP_SH +: chs_pkg::SUM_W];
    assign w_qmul = r_quot * chs_pkg::SUM_W'(BUCKETS);
    assign w_bkt  = r_acc[BKT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_bh_valid <= '0;
        end else begin
            if (i_ctl.append_term) begin
                r_used <= r_used + 1'b1;
            end
            if (i_ctl.append_link && (r_last == NULL_NODE)) begin
                r_bh_valid[w_bkt] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key    <= w_norm;
            r_search <= i_cmd;
            r_acc    <= '0;
            r_bidx   <= '0;
            r_mstep  <= chs_pkg::MSTEP_W'(chs_pkg::MOD_STEPS - 1);
        end
        if (i_ctl.sum_step) begin
            r_acc  <= r_acc + chs_pkg::SUM_W'(w_byte);
            r_bidx <= r_bidx + 1'b1;
        end
        if (i_ctl.mod_step) begin
            if (r_mstep != '0) begin
                r_quot <= w_quot;
            end else begin
                r_acc <= r_acc - w_qmul;
            end
            r_mstep <= r_mstep - 1'b1;
        end
        if (i_ctl.head_take) begin
            r_node  <= r_bh_rdv ? r_bh_rd : NULL_NODE;
            r_last  <= NULL_NODE;
            r_steps <= '0;
        end
        if (i_ctl.node_adv) begin
            r_last  <= r_node;
            r_node  <= r_rd_next;
            r_steps <= r_steps + 1'b1;
        end
        if (i_ctl.set_status) begin
            r_status <= i_ctl.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.head_rd) begin
            r_bh_rd  <= r_bh_mem[w_bkt];
            r_bh_rdv <= r_bh_valid[w_bkt];
        end
        if (i_ctl.append_link && (r_last == NULL_NODE)) begin
            r_bh_mem[w_bkt] <= r_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.node_rd) begin
            r_rd_key <= r_key_mem[r_node[PIDX_W-1:0]];
        end
        if (i_ctl.append_term) begin
            r_key_mem[r_used[PIDX_W-1:0]] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.node_rd) begin
            r_rd_next <= r_next_mem[r_node[PIDX_W-1:0]];
        end
        if (i_ctl.append_link && (r_last != NULL_NODE)) begin
            r_next_mem[r_last[PIDX_W-1:0]] <= r_used;
        end else if (i_ctl.append_term) begin
            r_next_mem[r_used[PIDX_W-1:0]] <= NULL_NODE;
        end
    end

    always_comb begin
        o_stat.sum_last  = (r_bidx == chs_pkg::BIDX_W'(KEY_BYTES - 1));
        o_stat.mod_last  = (r_mstep == '0);
        o_stat.walk_ok   = (r_node < r_used) && (r_steps < r_used);
        o_stat.key_match = (r_rd_key == r_key);
        o_stat.pool_full = (r_used == NULL_NODE);
        o_stat.is_search = (r_search == chs_pkg::CMD_SEARCH);
    end

    assign o_status = r_status;
    assign o_bucket = chs_pkg::BUCKET_W'(w_bkt);

endmodule

`default_nettype wire

### hdl/chained_hash_set.sv
// Top level of the chained hash set: joins the controller and the datapath.
// Depends on chs_pkg, chs_ctrl and chs_dp.
//
//   Channel   Handshake             Payload
//   request   start, busy           i_cmd, i_key_head, i_key_tail
//   result    o_valid (one cycle)   o_status, o_bucket
//
// A request runs through the byte-serial hash sum, the reciprocal modulo and the
// bucket head read, then walks the chain over the registered pool memory; a hit
// ends at the key compare of its node, sooner than a miss, and an insert that
// appends a node passes through the link and terminate states before the strobe.
// busy is high through the strobe and the next transfer can come in the cycle
// after it. Synchronous reset empties every bucket and the pool; the receiver
// cannot stall.
`default_nettype none

module chained_hash_set #(
    parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF,
    parameter int KEY_BYTES  = chs_pkg::KEY_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cmd,
    input  wire logic [63:0]                   i_key_head,
    input  wire logic [7:0]                    i_key_tail,
    output logic                               o_valid,
    output logic [chs_pkg::STATUS_W-1:0]       o_status,
    output logic [chs_pkg::BUCKET_W-1:0]       o_bucket
);

    chs_pkg::t_dp_cmd  w_cmd;
    chs_pkg::t_dp_stat w_stat;

    chs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    chs_dp #(
        .BUCKETS    (BUCKETS),
        .POOL_NODES (POOL_NODES),
        .KEY_BYTES  (KEY_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_key_head (i_key_head),
        .i_key_tail (i_key_tail),
        .i_ctl      (w_cmd),
        .o_stat     (w_stat),
        .o_status   (o_status),
        .o_bucket   (o_bucket)
    );

endmodule

`default_nettype wire
